/* rtl/assert_macros.svh */
// Assertion macros used by the checker of the column decimator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMCD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("smcd: property violated");

// Next-cycle implication, disabled while reset is asserted.
`define SMCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("smcd: property violated");

`endif

/* rtl/smcd_pkg.sv */
// Types and constants of the scope min/max column decimator.
`default_nettype none

package smcd_pkg;

	// Fixed widths of the channel payload and the register port address.
	localparam int SAMPLE_W = 16;
	localparam int POS_W    = 10;
	localparam int PADDR_W  = 3;

	// Phase accumulator: one sample is 1.0 in Q.8, and the period never drops below it.
	localparam logic [32:0] PHASE_STEP    = 33'd256;
	localparam logic [31:0] MIN_PERIOD_Q8 = 32'd256;

	// Register indexes, decoded from paddr[2].
	localparam logic REG_CHANNEL_MODE       = 1'b0;
	localparam logic REG_SAMPLES_PER_COLUMN = 1'b1;

	typedef enum logic [1:0] {
		ACT_SAMPLE = 2'd0,
		ACT_CLEAR  = 2'd1,
		ACT_READ   = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		MODE_STEREO = 2'd0,
		MODE_LEFT   = 2'd1,
		MODE_RIGHT  = 2'd2,
		MODE_DIFF   = 2'd3
	} chan_mode_t;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_EXEC
	} state_t;

	// One display column as it sits in the store.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] first_min;
		logic signed [SAMPLE_W-1:0] first_max;
		logic signed [SAMPLE_W-1:0] second_min;
		logic signed [SAMPLE_W-1:0] second_max;
		logic signed [SAMPLE_W-1:0] first_point;
		logic signed [SAMPLE_W-1:0] second_point;
	} column_t;

	// Per-sample controls for the column update.
	typedef struct packed {
		chan_mode_t mode;
		logic       zoom;
	} upd_ctrl_t;

endpackage

`default_nettype wire

/* rtl/smcd_channels.sv */
// Handshake interfaces for the item and result channels.
`default_nettype none

interface smcd_item_if import smcd_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 action;
	logic signed [SAMPLE_W-1:0] left_sample;
	logic signed [SAMPLE_W-1:0] right_sample;
	logic                       batch_end;
	logic [POS_W-1:0]           read_column;

	modport source (output valid, action, left_sample, right_sample, batch_end, read_column,
		input ready);
	modport sink (input valid, action, left_sample, right_sample, batch_end, read_column,
		output ready);
	modport monitor (input valid, ready, action, left_sample, right_sample, batch_end,
		read_column);
endinterface

interface smcd_result_if import smcd_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic [POS_W-1:0]           column_index;
	logic signed [SAMPLE_W-1:0] first_min;
	logic signed [SAMPLE_W-1:0] first_max;
	logic signed [SAMPLE_W-1:0] second_min;
	logic signed [SAMPLE_W-1:0] second_max;
	logic signed [SAMPLE_W-1:0] first_point;
	logic signed [SAMPLE_W-1:0] second_point;
	logic                       column_advanced;
	logic [POS_W-1:0]           write_position;
	logic                       zoomed;
	logic                       data_ready;

	modport source (output valid, column_index, first_min, first_max, second_min, second_max,
		first_point, second_point, column_advanced, write_position, zoomed, data_ready,
		input ready);
	modport sink (input valid, column_index, first_min, first_max, second_min, second_max,
		first_point, second_point, column_advanced, write_position, zoomed, data_ready,
		output ready);
	modport monitor (input valid, ready, column_index, first_min, first_max, second_min,
		second_max, first_point, second_point, column_advanced, write_position, zoomed,
		data_ready);
endinterface

`default_nettype wire

/* rtl/scope_minmax_column_decimator.sv */
// Top level of the scope min/max column decimator: column store, phase and register port.
//
//   Channel  Direction  Carries
//   item     in         action, left/right sample, batch end, read column
//   result   out        column contents, column index, fill position, flags
//   apb      in/out     channel_mode at 0x0, samples_per_column_q8 at 0x4
//
// A sample, read or idle action runs as a transfer, which issues the store read, and an update
// step, which loads the result from the registered read data; a sample also writes its column.
// A clear runs those steps and then a pass over the store that zeroes every column.
// After reset the same pass runs before the first item is taken.
// While a result waits in the output register the next item is still taken, but its
// update step holds until the output register is free.
`default_nettype none

module scope_minmax_column_decimator import smcd_pkg::*; #(
	parameter int COLUMNS       = 1024,
	parameter int ZOOM_LIMIT_Q8 = 6400
) (
	input  logic               clk,
	input  logic               arst_n,
	smcd_item_if.sink          item,
	smcd_result_if.source      result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int             CW       = $clog2(COLUMNS);
	localparam logic [CW-1:0]  LAST_COL = CW'(COLUMNS - 1);
	localparam logic [31:0]    COL_CNT  = 32'(COLUMNS);
	localparam logic [31:0]    ZOOM_LIM = 32'(ZOOM_LIMIT_Q8);

	function automatic logic [POS_W-1:0] to_pos(input logic [CW-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[POS_W-1:0];
	endfunction

	// Control and configuration state.
	state_t        state_q, state_nx;
	logic [CW-1:0] sweep_q;
	logic [CW-1:0] fill_q;
	logic [31:0]   phase_q;
	logic          fresh_q;
	chan_mode_t    mode_q;
	logic [31:0]   spc_q;

	// Item captured at the transfer.
	action_t                    act_s1;
	logic signed [SAMPLE_W-1:0] left_s1;
	logic signed [SAMPLE_W-1:0] right_s1;
	logic                       batch_s1;
	logic [POS_W-1:0]           rdcol_s1;
	logic                       rd_ok_s1;
	logic [CW-1:0]              addr_s1;

	// Column store.
	column_t       mem [COLUMNS];
	column_t       mem_rd_q;
	logic          mem_re;
	logic [CW-1:0] mem_ra;
	logic          mem_we;
	logic [CW-1:0] mem_wa;
	column_t       mem_wd;

	logic          accept;
	logic          commit;
	logic          cfg_wr;
	logic [31:0]   rc_wide;
	logic [31:0]   period;
	logic          zoom;
	logic [32:0]   phase_sum;
	logic          advance;
	logic [31:0]   phase_nx;
	logic [CW-1:0] next_col;
	column_t       old_col;
	column_t       new_col;
	upd_ctrl_t     upd_ctrl;

	// Result register and its next value.
	logic             out_valid_q;
	logic [POS_W-1:0] out_index_q, res_index;
	column_t          out_col_q, res_col;
	logic             out_adv_q, res_adv;
	logic [POS_W-1:0] out_wpos_q, res_wpos;
	logic             out_zoom_q;
	logic             out_ready_q, res_ready;

	assign accept  = item.valid && item.ready;
	assign commit  = (state_q == ST_EXEC) && (!out_valid_q || result.ready);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign rc_wide = 32'(item.read_column);

	// Register port.
	assign pready = 1'b1;

	always_comb begin
		case (paddr[2])
			REG_CHANNEL_MODE:       prdata = {30'd0, mode_q};
			REG_SAMPLES_PER_COLUMN: prdata = spc_q;
			default:                prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_STEREO;
			spc_q  <= MIN_PERIOD_Q8;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_CHANNEL_MODE:       mode_q <= chan_mode_t'(pwdata[1:0]);
				REG_SAMPLES_PER_COLUMN: spc_q  <= pwdata;
				default:                spc_q  <= spc_q;
			endcase
		end
	end

	// Period, mode and phase step.
	always_comb begin
		period    = (spc_q < MIN_PERIOD_Q8) ? MIN_PERIOD_Q8 : spc_q;
		zoom      = (period <= ZOOM_LIM);
		phase_sum = {1'b0, phase_q} + PHASE_STEP;
		advance   = (phase_sum >= {1'b0, period});
		phase_nx  = advance ? 32'(phase_sum - {1'b0, period}) : phase_sum[31:0];
		next_col  = (fill_q == LAST_COL) ? '0 : fill_q + 1'b1;
		upd_ctrl  = '{mode: mode_q, zoom: zoom};
	end

	// The column at the fill position reads as zero until its first sample after an advance.
	assign old_col = (fresh_q && (addr_s1 == fill_q)) ? column_t'('0) : mem_rd_q;

	smcd_column_math u_math (
		.ctrl         (upd_ctrl),
		.left_sample  (left_s1),
		.right_sample (right_s1),
		.old_col      (old_col),
		.new_col      (new_col)
	);

	// Result contents for each action.
	always_comb begin
		res_index = to_pos(fill_q);
		res_col   = old_col;
		res_adv   = 1'b0;
		res_wpos  = to_pos(fill_q);
		res_ready = 1'b0;
		case (act_s1)
			ACT_SAMPLE: begin
				res_col   = new_col;
				res_adv   = advance;
				res_wpos  = advance ? to_pos(next_col) : to_pos(fill_q);
				res_ready = batch_s1;
			end
			ACT_CLEAR: begin
				res_index = '0;
				res_col   = '0;
				res_wpos  = '0;
				res_ready = 1'b1;
			end
			ACT_READ: begin
				res_index = rdcol_s1;
				res_col   = rd_ok_s1 ? old_col : column_t'('0);
			end
			default: begin
				res_col = old_col;
			end
		endcase
	end

	// Sequencer: next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_SWEEP: begin
				if (sweep_q == LAST_COL) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (commit) begin
					state_nx = (act_s1 == ACT_CLEAR) ? ST_SWEEP : ST_IDLE;
				end
			end
			default: state_nx = ST_SWEEP;
		endcase
	end

	// Sequencer: store and handshake controls.
	always_comb begin
		item.ready = (state_q == ST_IDLE);
		mem_re     = accept;
		mem_ra     = (item.action == ACT_READ) ? rc_wide[CW-1:0] : fill_q;
		mem_we     = 1'b0;
		mem_wa     = fill_q;
		mem_wd     = new_col;
		case (state_q)
			ST_SWEEP: begin
				mem_we = 1'b1;
				mem_wa = sweep_q;
				mem_wd = '0;
			end
			ST_EXEC: begin
				mem_we = commit && (act_s1 == ACT_SAMPLE);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Column store with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			mem_rd_q <= mem[mem_ra];
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1   <= action_t'(item.action);
			left_s1  <= item.left_sample;
			right_s1 <= item.right_sample;
			batch_s1 <= item.batch_end;
			rdcol_s1 <= item.read_column;
			rd_ok_s1 <= (rc_wide < COL_CNT);
			addr_s1  <= mem_ra;
		end
	end

	// Sequencer state, sweep counter, fill position and phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			sweep_q <= '0;
			fill_q  <= '0;
			phase_q <= '0;
			fresh_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_SWEEP) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (commit) begin
				case (act_s1)
					ACT_SAMPLE: begin
						phase_q <= phase_nx;
						fresh_q <= advance;
						if (advance) begin
							fill_q <= next_col;
						end
					end
					ACT_CLEAR: begin
						sweep_q <= '0;
						fill_q  <= '0;
						phase_q <= '0;
						fresh_q <= 1'b0;
					end
					default: begin
						fresh_q <= fresh_q;
					end
				endcase
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_index_q <= res_index;
			out_col_q   <= res_col;
			out_adv_q   <= res_adv;
			out_wpos_q  <= res_wpos;
			out_zoom_q  <= zoom;
			out_ready_q <= res_ready;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.column_index    = out_index_q;
	assign result.first_min       = out_col_q.first_min;
	assign result.first_max       = out_col_q.first_max;
	assign result.second_min      = out_col_q.second_min;
	assign result.second_max      = out_col_q.second_max;
	assign result.first_point     = out_col_q.first_point;
	assign result.second_point    = out_col_q.second_point;
	assign result.column_advanced = out_adv_q;
	assign result.write_position  = out_wpos_q;
	assign result.zoomed          = out_zoom_q;
	assign result.data_ready      = out_ready_q;

endmodule

`default_nettype wire

/* rtl/smcd_column_math.sv */
// Folds one stereo sample into a stored column, in point or peak mode.
`default_nettype none

module smcd_column_math import smcd_pkg::*; (
	input  upd_ctrl_t                  ctrl,
	input  logic signed [SAMPLE_W-1:0] left_sample,
	input  logic signed [SAMPLE_W-1:0] right_sample,
	input  column_t                    old_col,
	output column_t                    new_col
);

	localparam logic signed [SAMPLE_W:0] SAT_HI = 17'sd32767;
	localparam logic signed [SAMPLE_W:0] SAT_LO = -17'sd32768;

	logic signed [SAMPLE_W:0]   diff;
	logic signed [SAMPLE_W-1:0] diff_sat;
	logic signed [SAMPLE_W-1:0] ch_a;
	logic signed [SAMPLE_W-1:0] ch_b;
	logic                       stereo;

	// Saturated left minus right.
	always_comb begin
		diff = {left_sample[SAMPLE_W-1], left_sample} - {right_sample[SAMPLE_W-1], right_sample};
		if (diff > SAT_HI) begin
			diff_sat = SAT_HI[SAMPLE_W-1:0];
		end else if (diff < SAT_LO) begin
			diff_sat = SAT_LO[SAMPLE_W-1:0];
		end else begin
			diff_sat = diff[SAMPLE_W-1:0];
		end
	end

	// Channel routing; the second channel is only fed in stereo.
	always_comb begin
		stereo = (ctrl.mode == MODE_STEREO);
		ch_b   = '0;
		case (ctrl.mode)
			MODE_STEREO: begin
				ch_a = left_sample;
				ch_b = right_sample;
			end
			MODE_LEFT:  ch_a = left_sample;
			MODE_RIGHT: ch_a = right_sample;
			MODE_DIFF:  ch_a = diff_sat;
			default:    ch_a = left_sample;
		endcase
	end

	// Point mode keeps the newest sample; peak mode widens min and max.
	always_comb begin
		new_col = old_col;
		if (ctrl.zoom) begin
			new_col.first_point = ch_a;
			new_col.first_min   = ch_a;
			new_col.first_max   = ch_a;
			if (stereo) begin
				new_col.second_point = ch_b;
			end
			new_col.second_min = stereo ? ch_b : old_col.second_point;
			new_col.second_max = stereo ? ch_b : old_col.second_point;
		end else begin
			if (ch_a < old_col.first_min) begin
				new_col.first_min = ch_a;
			end
			if (ch_a > old_col.first_max) begin
				new_col.first_max = ch_a;
			end
			if (stereo && (ch_b < old_col.second_min)) begin
				new_col.second_min = ch_b;
			end
			if (stereo && (ch_b > old_col.second_max)) begin
				new_col.second_max = ch_b;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/smcd_checker.sv */
// Port-level checks of the column decimator, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module smcd_checker import smcd_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       item_valid,
	input logic                       item_ready,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [POS_W-1:0]           res_index,
	input logic signed [SAMPLE_W-1:0] res_first_min,
	input logic signed [SAMPLE_W-1:0] res_first_max,
	input logic signed [SAMPLE_W-1:0] res_second_min,
	input logic signed [SAMPLE_W-1:0] res_second_max,
	input logic signed [SAMPLE_W-1:0] res_first_point,
	input logic [POS_W-1:0]           res_wpos,
	input logic                       res_zoomed,
	input logic                       res_advanced,
	input logic                       res_data_ready
);

	logic                               res_stall;
	logic [POS_W+2*SAMPLE_W+POS_W:0]    res_word;
	logic                               zoom_close;
	logic                               zoom_equal;
	logic                               order_ok;

	assign res_stall  = res_valid && !res_ready;
	assign res_word   = {res_index, res_first_min, res_first_max, res_wpos, res_data_ready};
	assign zoom_close = res_valid && res_zoomed && res_advanced;
	assign zoom_equal = (res_first_min == res_first_point) && (res_first_max == res_first_point);
	assign order_ok   = (res_first_min <= res_first_max) && (res_second_min <= res_second_max);

	// A stalled result stays valid and keeps its res_word fields until it is taken.
	`SMCD_ASSERT_NEXT(a_result_held, clk, arst_n, res_stall, res_valid && $stable(res_word))

	// Items are handled one at a time, so a transfer drops ready for the next cycle.
	`SMCD_ASSERT_NEXT(a_one_item_at_a_time, clk, arst_n, item_valid && item_ready, !item_ready)

	// A sample that closes a column in point mode leaves min, max and point equal.
	`SMCD_ASSERT_SAME(a_zoom_point_equal, clk, arst_n, zoom_close, zoom_equal)

	// Every column, in either mode, keeps its minimum at or below its maximum.
	`SMCD_ASSERT_SAME(a_min_not_above_max, clk, arst_n, res_valid, order_ok)

endmodule

bind scope_minmax_column_decimator smcd_checker u_smcd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item.valid),
	.item_ready     (item.ready),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.res_index      (result.column_index),
	.res_first_min  (result.first_min),
	.res_first_max  (result.first_max),
	.res_second_min (result.second_min),
	.res_second_max (result.second_max),
	.res_first_point(result.first_point),
	.res_wpos       (result.write_position),
	.res_zoomed     (result.zoomed),
	.res_advanced   (result.column_advanced),
	.res_data_ready (result.data_ready)
);

`default_nettype wire
